FILE: design/bvr_pkg.sv
// Shared types and constants for the bitstream VLC reader.
// Used by bvr_bit_source, bvr_decoder and bitstream_vlc_reader_core.
package bvr_pkg;

    localparam int unsigned WIN_W   = 64;
    localparam int unsigned VAL_W   = 64;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned TOTAL_W = 32;

    // Request kinds carried in req_type
    typedef enum logic [2:0] {
        REQ_BIT    = 3'd0,
        REQ_UCODE  = 3'd1,
        REQ_SCODE  = 3'd2,
        REQ_BYTE   = 3'd3,
        REQ_WORD16 = 3'd4,
        REQ_WORD32 = 3'd5,
        REQ_WORD64 = 3'd6
    } req_kind_t;

    // Byte counts for the whole-byte reads
    localparam logic [CNT_W-1:0] BYTES_NONE = 4'd0;
    localparam logic [CNT_W-1:0] BYTES_B8   = 4'd1;
    localparam logic [CNT_W-1:0] BYTES_W16  = 4'd2;
    localparam logic [CNT_W-1:0] BYTES_W32  = 4'd4;
    localparam logic [CNT_W-1:0] BYTES_W64  = 4'd8;

    // Decoder to bit source control
    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] load_count;
        logic             take;
    } bs_ctrl_t;

    // Bit source status for the current take
    typedef struct packed {
        logic             bit_val;
        logic             over;
        logic [CNT_W-1:0] count;
    } bs_stat_t;

    // Finished result handed to the output stage
    typedef struct packed {
        logic             fin;
        logic [VAL_W-1:0] value;
        logic             err;
    } dec_result_t;

endpackage

FILE: design/bvr_bit_source.sv
// Bit source: persistent LSB-first bit buffer fed from a byte shift register.
// Depends on bvr_pkg for the control and status structs.
module bvr_bit_source
    import bvr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  bs_ctrl_t         ctrl,
    input  logic [WIN_W-1:0] window,
    output bs_stat_t         stat
);

    logic [7:0]       buf_reg, buf_next;
    logic [2:0]       used_reg, used_next;
    logic [WIN_W-1:0] win_reg, win_next;
    logic [CNT_W-1:0] next_reg, next_next;
    logic             reload;
    logic             win_empty;
    logic [7:0]       src_byte;

    // Pick the byte the next bit comes from
    always_comb
    begin
        win_empty = next_reg[CNT_W-1];
        reload    = (used_reg == 3'd0);
        if (reload)
        begin
            src_byte = win_empty ? 8'd0 : win_reg[7:0];
        end
        else
        begin
            src_byte = buf_reg;
        end
        stat.bit_val = src_byte[0];
        stat.over    = reload & win_empty;
        stat.count   = next_reg;
    end

    // Advance buffer and window on a take, reload window on a new transaction
    always_comb
    begin
        buf_next  = buf_reg;
        used_next = used_reg;
        win_next  = win_reg;
        next_next = next_reg;
        if (ctrl.load)
        begin
            win_next  = window;
            next_next = ctrl.load_count;
        end
        else if (ctrl.take)
        begin
            buf_next  = {1'b0, src_byte[7:1]};
            used_next = used_reg + 3'd1;
            if (reload && !win_empty)
            begin
                win_next  = {8'd0, win_reg[WIN_W-1:8]};
                next_next = next_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg  <= '0;
            used_reg <= '0;
            next_reg <= '0;
        end
        else
        begin
            buf_reg  <= buf_next;
            used_reg <= used_next;
            next_reg <= next_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

FILE: design/bvr_decoder.sv
// Request sequencer: walks variable-length codes one bit per cycle.
// Depends on bvr_pkg; drives bvr_bit_source through bs_ctrl_t.
module bvr_decoder
    import bvr_pkg::*;
#(
    parameter int unsigned SIGNED_EXTRA_BITS = 6,
    parameter int unsigned MAX_UNSIGNED_BITS = 31
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       req_type,
    input  logic [WIN_W-1:0] stream_window,
    input  bs_stat_t         stat,
    output bs_ctrl_t         ctrl,
    input  logic             fin_free,
    output dec_result_t      result
);

    localparam int unsigned WW = $clog2(MAX_UNSIGNED_BITS + 1);
    localparam int unsigned IW = $clog2(SIGNED_EXTRA_BITS + 1);
    localparam logic [WW-1:0] MAX_WIDTH = WW'(MAX_UNSIGNED_BITS);
    localparam logic [IW-1:0] MAX_EXTRA = IW'(SIGNED_EXTRA_BITS);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_BIT     = 10'b0000000010,
        ST_U_FIRST = 10'b0000000100,
        ST_U_VAL   = 10'b0000001000,
        ST_U_CONT  = 10'b0000010000,
        ST_S_FIRST = 10'b0000100000,
        ST_S_SIGN  = 10'b0001000000,
        ST_S_CONT  = 10'b0010000000,
        ST_S_VAL   = 10'b0100000000,
        ST_FIN     = 10'b1000000000
    } dec_state_t;

    dec_state_t       state_reg, state_next;
    logic [VAL_W-1:0] t_reg, t_next;
    logic [WW-1:0]    width_reg, width_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic             neg_reg, neg_next;
    logic             zero_reg, zero_next;
    logic             dec_reg, dec_next;
    logic             err_reg, err_next;
    logic [VAL_W-1:0] t_shift;

    assign in_ready = (state_reg == ST_IDLE);
    assign t_shift  = {t_reg[VAL_W-2:0], stat.bit_val};

    // Sequence one bit per cycle through the code being read
    always_comb
    begin
        state_next      = state_reg;
        t_next          = t_reg;
        width_next      = width_reg;
        idx_next        = idx_reg;
        neg_next        = neg_reg;
        zero_next       = zero_reg;
        dec_next        = dec_reg;
        err_next        = err_reg;
        ctrl.load       = 1'b0;
        ctrl.load_count = BYTES_NONE;
        ctrl.take       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    t_next     = VAL_W'(1);
                    width_next = WW'(1);
                    idx_next   = '0;
                    neg_next   = 1'b0;
                    zero_next  = 1'b0;
                    dec_next   = 1'b0;
                    err_next   = 1'b0;
                    case (req_type)
                        REQ_BIT:    state_next = ST_BIT;
                        REQ_UCODE:  state_next = ST_U_FIRST;
                        REQ_SCODE:  state_next = ST_S_FIRST;
                        REQ_BYTE:
                        begin
                            t_next          = {56'd0, stream_window[7:0]};
                            ctrl.load_count = BYTES_B8;
                            state_next      = ST_FIN;
                        end
                        REQ_WORD16:
                        begin
                            t_next          = {48'd0, stream_window[15:0]};
                            ctrl.load_count = BYTES_W16;
                            state_next      = ST_FIN;
                        end
                        REQ_WORD32:
                        begin
                            t_next          = {32'd0, stream_window[31:0]};
                            ctrl.load_count = BYTES_W32;
                            state_next      = ST_FIN;
                        end
                        REQ_WORD64:
                        begin
                            t_next          = stream_window;
                            ctrl.load_count = BYTES_W64;
                            state_next      = ST_FIN;
                        end
                        default:
                        begin
                            zero_next  = 1'b1;
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_BIT:
            begin
                ctrl.take  = 1'b1;
                t_next     = {{(VAL_W-1){1'b0}}, stat.bit_val};
                state_next = ST_FIN;
            end
            ST_U_FIRST:
            begin
                ctrl.take = 1'b1;
                if (!stat.bit_val)
                begin
                    zero_next  = 1'b1;
                    state_next = ST_FIN;
                end
                else if (stat.over)
                begin
                    zero_next  = 1'b1;
                    err_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_U_VAL;
                end
            end
            ST_U_VAL:
            begin
                // Drop the code once it would grow past the width limit
                if (width_reg >= MAX_WIDTH)
                begin
                    zero_next  = 1'b1;
                    err_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    ctrl.take = 1'b1;
                    if (stat.over)
                    begin
                        zero_next  = 1'b1;
                        err_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        t_next     = t_shift;
                        width_next = width_reg + WW'(1);
                        state_next = ST_U_CONT;
                    end
                end
            end
            ST_U_CONT:
            begin
                ctrl.take = 1'b1;
                if (stat.over)
                begin
                    zero_next  = 1'b1;
                    err_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else if (!stat.bit_val)
                begin
                    dec_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_U_VAL;
                end
            end
            ST_S_FIRST:
            begin
                ctrl.take = 1'b1;
                if (!stat.bit_val)
                begin
                    zero_next  = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_S_SIGN;
                end
            end
            ST_S_SIGN:
            begin
                ctrl.take  = 1'b1;
                neg_next   = stat.bit_val;
                state_next = ST_S_CONT;
            end
            ST_S_CONT:
            begin
                if (idx_reg == MAX_EXTRA)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    ctrl.take = 1'b1;
                    if (!stat.bit_val)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_S_VAL;
                    end
                end
            end
            ST_S_VAL:
            begin
                ctrl.take  = 1'b1;
                t_next     = t_shift;
                idx_next   = idx_reg + IW'(1);
                state_next = ST_S_CONT;
            end
            ST_FIN:
            begin
                // Hold until the output register can take the transaction
                if (fin_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Form the final value from the collected bits
    always_comb
    begin
        result.fin = (state_reg == ST_FIN);
        result.err = err_reg;
        if (zero_reg)
        begin
            result.value = '0;
        end
        else if (dec_reg)
        begin
            result.value = t_reg - VAL_W'(1);
        end
        else if (neg_reg)
        begin
            result.value = '0 - t_reg;
        end
        else
        begin
            result.value = t_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            width_reg <= '0;
            idx_reg   <= '0;
            neg_reg   <= 1'b0;
            zero_reg  <= 1'b0;
            dec_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            width_reg <= width_next;
            idx_reg   <= idx_next;
            neg_reg   <= neg_next;
            zero_reg  <= zero_next;
            dec_reg   <= dec_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
    end

endmodule

FILE: design/bitstream_vlc_reader_core.sv
// Bitstream VLC reader, top level. Bits are consumed one per cycle.
// One request is worked at a time; the next is accepted the cycle after the result enters
// the output register.
// Reset clears the bit buffer, its bit count, the byte total and all handshake state.
module bitstream_vlc_reader_core
    import bvr_pkg::*;
#(
    parameter int unsigned SIGNED_EXTRA_BITS = 6,
    parameter int unsigned MAX_UNSIGNED_BITS = 31
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic [WIN_W-1:0]   stream_window,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VAL_W-1:0]   value,
    output logic [CNT_W-1:0]   bytes_consumed,
    output logic [TOTAL_W-1:0] total_bytes,
    output logic               code_error
);

    bs_ctrl_t    ctrl;
    bs_stat_t    stat;
    dec_result_t result;
    logic        fin_free;
    logic        out_load;

    logic               out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]   value_reg;
    logic [CNT_W-1:0]   bytes_reg;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               error_reg;

    bvr_bit_source u_bit_source (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .window (stream_window),
        .stat   (stat)
    );

    bvr_decoder #(
        .SIGNED_EXTRA_BITS (SIGNED_EXTRA_BITS),
        .MAX_UNSIGNED_BITS (MAX_UNSIGNED_BITS)
    ) u_decoder (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .stream_window (stream_window),
        .stat          (stat),
        .ctrl          (ctrl),
        .fin_free      (fin_free),
        .result        (result)
    );

    // Move a finished transaction into the output register when it is free
    always_comb
    begin
        fin_free       = !out_valid_reg || out_ready;
        out_load       = result.fin && fin_free;
        total_next     = total_reg + TOTAL_W'(stat.count);
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            value_reg <= result.value;
            bytes_reg <= stat.count;
            error_reg <= result.err;
        end
    end

    assign out_valid      = out_valid_reg;
    assign value          = value_reg;
    assign bytes_consumed = bytes_reg;
    assign total_bytes    = total_reg;
    assign code_error     = error_reg;

endmodule

FILE: tb/bvr_checker.sv
// Scoreboard for the bitstream VLC reader: watches both channels, predicts each
// read from its own bit buffer model and compares results in order.
// Depends on bvr_pkg for request kinds, widths and byte counts.
module bvr_checker
    import bvr_pkg::*;
#(
    parameter int unsigned SIGNED_EXTRA_BITS = 6,
    parameter int unsigned MAX_UNSIGNED_BITS = 31
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic [WIN_W-1:0]   stream_window,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [VAL_W-1:0]   value,
    input  logic [CNT_W-1:0]   bytes_consumed,
    input  logic [TOTAL_W-1:0] total_bytes,
    input  logic               code_error,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [VAL_W-1:0]   value;
        logic [CNT_W-1:0]   nbytes;
        logic [TOTAL_W-1:0] total;
        logic               err;
    } read_result_t;

    // Reader state as seen from the stream
    logic [7:0]         bit_buf;
    logic [2:0]         bit_cnt;
    logic [TOTAL_W-1:0] byte_count;

    // Window of the transaction being decoded
    logic [WIN_W-1:0]   win_data;
    int unsigned        win_pos;
    logic               win_over;

    read_result_t       result_q[$];

    // Take one bit LSB first, refilling from the window when the count wraps
    function automatic logic next_bit();
        logic b;
        if (bit_cnt == 3'd0)
        begin
            if (win_pos < 8)
            begin
                bit_buf = win_data[8*win_pos +: 8];
                win_pos++;
            end
            else
            begin
                bit_buf  = 8'd0;
                win_over = 1'b1;
            end
        end
        b       = bit_buf[0];
        bit_buf = bit_buf >> 1;
        bit_cnt = bit_cnt + 3'd1;
        return b;
    endfunction

    // Interleaved gamma: leading one, then (value, continue) pairs; result t-1
    function automatic logic [VAL_W-1:0] gamma_unsigned(output logic err);
        logic [VAL_W-1:0] t;
        int unsigned      width;
        logic             vb;
        logic             more;
        err   = 1'b0;
        t     = 64'd1;
        width = 1;
        if (next_bit() == 1'b0)
            return 64'd0;
        if (win_over)
        begin
            err = 1'b1;
            return 64'd0;
        end
        do
        begin
            if (width + 1 > MAX_UNSIGNED_BITS)
            begin
                err = 1'b1;
                return 64'd0;
            end
            vb = next_bit();
            if (win_over)
            begin
                err = 1'b1;
                return 64'd0;
            end
            t = {t[VAL_W-2:0], vb};
            width++;
            more = next_bit();
        end
        while (more && !win_over);
        if (win_over)
        begin
            err = 1'b1;
            return 64'd0;
        end
        return t - 64'd1;
    endfunction

    // Signed code: nonzero flag, sign, then bounded (continue, value) pairs
    function automatic logic [VAL_W-1:0] gamma_signed();
        logic [VAL_W-1:0] t;
        logic             neg;
        t = 64'd1;
        if (next_bit() == 1'b0)
            return 64'd0;
        neg = next_bit();
        for (int unsigned i = 0; i < SIGNED_EXTRA_BITS; i++)
        begin
            if (next_bit() == 1'b0)
                break;
            t = {t[VAL_W-2:0], next_bit()};
        end
        return neg ? (64'd0 - t) : t;
    endfunction

    function automatic read_result_t decode_read(input logic [2:0] kind,
                                                 input logic [WIN_W-1:0] win);
        read_result_t r;
        logic         e;
        win_data = win;
        win_pos  = 0;
        win_over = 1'b0;
        r.value  = '0;
        r.err    = 1'b0;
        case (req_kind_t'(kind))
            REQ_BIT:    r.value = {63'd0, next_bit()};
            REQ_UCODE:
            begin
                r.value = gamma_unsigned(e);
                r.err   = e;
            end
            REQ_SCODE:  r.value = gamma_signed();
            REQ_BYTE:
            begin
                r.value = {56'd0, win[7:0]};
                win_pos = 32'(BYTES_B8);
            end
            REQ_WORD16:
            begin
                r.value = {48'd0, win[15:0]};
                win_pos = 32'(BYTES_W16);
            end
            REQ_WORD32:
            begin
                r.value = {32'd0, win[31:0]};
                win_pos = 32'(BYTES_W32);
            end
            REQ_WORD64:
            begin
                r.value = win;
                win_pos = 32'(BYTES_W64);
            end
            default: ;
        endcase
        byte_count = byte_count + TOTAL_W'(win_pos);
        r.nbytes   = CNT_W'(win_pos);
        r.total    = byte_count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        read_result_t exp_r;
        int           errs;
        if (!rst_n)
        begin
            bit_buf    = 8'd0;
            bit_cnt    = 3'd0;
            byte_count = '0;
            result_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            errs = 0;
            // Compare a finished transaction against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("unexpected result: value %h, bytes %0d", value, bytes_consumed);
                    errs++;
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (value !== exp_r.value)
                    begin
                        $error("value: expected %h, got %h", exp_r.value, value);
                        errs++;
                    end
                    if (bytes_consumed !== exp_r.nbytes)
                    begin
                        $error("bytes_consumed: expected %0d, got %0d",
                               exp_r.nbytes, bytes_consumed);
                        errs++;
                    end
                    if (total_bytes !== exp_r.total)
                    begin
                        $error("total_bytes: expected %0d, got %0d", exp_r.total, total_bytes);
                        errs++;
                    end
                    if (code_error !== exp_r.err)
                    begin
                        $error("code_error: expected %b, got %b", exp_r.err, code_error);
                        errs++;
                    end
                end
            end
            // Predict each accepted request
            if (in_valid && in_ready)
                result_q.push_back(decode_read(req_type, stream_window));
            fail_count <= fail_count + errs;
            pending    <= result_q.size();
        end
    end

endmodule

FILE: tb/tb_bitstream_vlc_reader_core.sv
// Top of the bitstream VLC reader testbench: clock, reset, request stimulus,
// random output stalls, a watchdog and the verdict. Needs bvr_pkg and bvr_checker.
module tb_bitstream_vlc_reader_core;
    import bvr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SCODE_EXTRA    = 6;
    localparam int unsigned UCODE_MAX_BITS = 31;
    localparam int          RANDOM_READS   = 1500;
    localparam int          IDLE_LIMIT     = 4000;
    localparam int          DRAIN_CYCLES   = 100;
    localparam logic [2:0]  REQ_UNUSED     = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         req_type;
    logic [WIN_W-1:0]   stream_window;
    logic               out_valid;
    logic               out_ready;
    logic [VAL_W-1:0]   value;
    logic [CNT_W-1:0]   bytes_consumed;
    logic [TOTAL_W-1:0] total_bytes;
    logic               code_error;
    int                 fail_count;
    int                 pending;
    logic               calm;
    int                 idle_cycles;

    bitstream_vlc_reader_core #(
        .SIGNED_EXTRA_BITS (SCODE_EXTRA),
        .MAX_UNSIGNED_BITS (UCODE_MAX_BITS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .stream_window  (stream_window),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .value          (value),
        .bytes_consumed (bytes_consumed),
        .total_bytes    (total_bytes),
        .code_error     (code_error)
    );

    bvr_checker #(
        .SIGNED_EXTRA_BITS (SCODE_EXTRA),
        .MAX_UNSIGNED_BITS (UCODE_MAX_BITS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .stream_window  (stream_window),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .value          (value),
        .bytes_consumed (bytes_consumed),
        .total_bytes    (total_bytes),
        .code_error     (code_error),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then long; none in calm stretches
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Window whose bits are one except with odds 1 in zero_odds
    function automatic logic [WIN_W-1:0] dense_window(int unsigned zero_odds);
        logic [WIN_W-1:0] w;
        for (int i = 0; i < WIN_W; i++)
            w[i] = ($urandom_range(zero_odds - 1, 0) != 0);
        return w;
    endfunction

    function automatic logic [WIN_W-1:0] pick_window();
        int r;
        r = $urandom_range(9);
        case (r)
            0:       return '1;
            1:       return '0;
            2, 3, 4: return {$urandom, $urandom};
            5, 6:    return dense_window(4);
            7, 8:    return dense_window(16);
            default: return dense_window(64);
        endcase
    endfunction

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 18) return REQ_BIT;
        if (r < 48) return REQ_UCODE;
        if (r < 68) return REQ_SCODE;
        if (r < 76) return REQ_BYTE;
        if (r < 83) return REQ_WORD16;
        if (r < 90) return REQ_WORD32;
        if (r < 96) return REQ_WORD64;
        return REQ_UNUSED;
    endfunction

    // Hold the request until accepted, then idle for a random gap
    task automatic send_read(input logic [2:0] kind, input logic [WIN_W-1:0] win);
        int gap;
        in_valid      <= 1'b1;
        req_type      <= kind;
        stream_window <= win;
        do
            @(posedge clk);
        while (!in_ready);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        int          sent;
        logic [2:0]  kind;
        in_valid      = 1'b0;
        req_type      = REQ_BIT;
        stream_window = '0;
        out_ready     = 1'b0;
        rst_n         = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: walk a full buffer byte, then each kind at the extremes
        send_read(REQ_BIT, '1);
        repeat (7) send_read(REQ_BIT, {$urandom, $urandom});
        send_read(REQ_UCODE, '0);
        send_read(REQ_BIT, '0);
        send_read(REQ_UCODE, '1);
        send_read(REQ_UCODE, '1);
        send_read(REQ_UCODE, 64'h5555_5555_5555_5555);
        send_read(REQ_SCODE, '1);
        send_read(REQ_SCODE, '0);
        send_read(REQ_SCODE, 64'hAAAA_AAAA_AAAA_AAAA);
        send_read(REQ_BYTE, '1);
        send_read(REQ_WORD16, 64'h0123_4567_89AB_8001);
        send_read(REQ_WORD32, 64'hFFFF_FFFF_8000_0001);
        send_read(REQ_WORD64, '1);
        send_read(REQ_WORD64, 64'h8000_0000_0000_0001);
        send_read(REQ_UNUSED, '1);
        send_read(REQ_WORD64, '0);

        // Random reads; unused kinds do not count
        sent = 0;
        while (sent < RANDOM_READS)
        begin
            kind = pick_kind();
            send_read(kind, pick_window());
            if (kind != REQ_UNUSED)
                sent++;
        end
        in_valid <= 1'b0;

        // Let the checker count the last transaction before waiting on it
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Random back-pressure on the result channel
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    end

    // Alternate between stretches with and without idling
    initial
    begin
        calm = 1'b0;
        forever
        begin
            repeat ($urandom_range(400, 100)) @(posedge clk);
            calm <= ($urandom_range(3) == 0);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
